### src/rrl_pkg.sv
package rrl_pkg;

   localparam int TableEntriesDefault = 64;
   localparam int ValueBitsDefault    = 40;
   localparam int SLOT_BITS           = 6;
   localparam int COUNT_BITS          = 7;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   typedef struct packed {
      logic is_write;
      logic slot_ok;
   } cmd_ctrl_type;

endpackage

### src/range_remap_lookup.sv
// Channel   Ports                                Direction  Beat
// req       req_valid / req_ready, req_*         in         one lookup or one table write
// rsp       rsp_valid / rsp_ready, rsp_*         out        one translated value per lookup
// csr       csr_valid / csr_ready, csr_entry_count  in      new entry count
//
// A write beat is taken by the scan engine while it is idle; it causes no response.
// A lookup compares table entries in order, up to and including the first hit and at
// most min(entry_count, TABLE_ENTRIES) of them; the table RAM gives one entry per cycle
// on its single read port. Requests wait in a two-beat queue ahead of the scan engine.
// Reset is synchronous and clears control state only; table entries hold garbage until
// written. A stalled response holds the engine, and a full queue holds req_ready low.
module range_remap_lookup #(
   parameter int TABLE_ENTRIES = rrl_pkg::TableEntriesDefault,
   parameter int VALUE_BITS    = rrl_pkg::ValueBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [VALUE_BITS-1:0]          req_lookup_value,
   input  logic [rrl_pkg::SLOT_BITS-1:0]  req_slot,
   input  logic [VALUE_BITS-1:0]          req_dest_base,
   input  logic [VALUE_BITS-1:0]          req_source_base,
   input  logic [VALUE_BITS-1:0]          req_window_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [VALUE_BITS-1:0]          rsp_mapped_value,
   output logic                           rsp_hit,
   output logic [rrl_pkg::SLOT_BITS-1:0]  rsp_hit_slot,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrl_pkg::COUNT_BITS-1:0] csr_entry_count
);
   import rrl_pkg::*;

   logic [COUNT_BITS-1:0] entry_count_ff;
   logic                  head_valid;
   cmd_ctrl_type          head_ctrl;
   logic [VALUE_BITS-1:0] head_value;
   logic [SLOT_BITS-1:0]  head_slot;
   logic [VALUE_BITS-1:0] head_dest;
   logic [VALUE_BITS-1:0] head_source;
   logic [VALUE_BITS-1:0] head_length;
   logic                  head_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_valid) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   rrl_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_lookup_value  (req_lookup_value),
      .req_slot          (req_slot),
      .req_dest_base     (req_dest_base),
      .req_source_base   (req_source_base),
      .req_window_length (req_window_length),
      .head_valid        (head_valid),
      .head_ctrl         (head_ctrl),
      .head_value        (head_value),
      .head_slot         (head_slot),
      .head_dest         (head_dest),
      .head_source       (head_source),
      .head_length       (head_length),
      .head_pop          (head_pop)
   );

   rrl_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_count      (entry_count_ff),
      .head_valid       (head_valid),
      .head_ctrl        (head_ctrl),
      .head_value       (head_value),
      .head_slot        (head_slot),
      .head_dest        (head_dest),
      .head_source      (head_source),
      .head_length      (head_length),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_hit          (rsp_hit),
      .rsp_hit_slot     (rsp_hit_slot)
   );

endmodule

### src/rrl_ram.sv
module rrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rrl_front.sv
module rrl_front #(
   parameter int TABLE_ENTRIES = 64,
   parameter int VALUE_BITS    = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [VALUE_BITS-1:0]          req_lookup_value,
   input  logic [rrl_pkg::SLOT_BITS-1:0]  req_slot,
   input  logic [VALUE_BITS-1:0]          req_dest_base,
   input  logic [VALUE_BITS-1:0]          req_source_base,
   input  logic [VALUE_BITS-1:0]          req_window_length,
   output logic                           head_valid,
   output rrl_pkg::cmd_ctrl_type          head_ctrl,
   output logic [VALUE_BITS-1:0]          head_value,
   output logic [rrl_pkg::SLOT_BITS-1:0]  head_slot,
   output logic [VALUE_BITS-1:0]          head_dest,
   output logic [VALUE_BITS-1:0]          head_source,
   output logic [VALUE_BITS-1:0]          head_length,
   input  logic                           head_pop
);
   import rrl_pkg::*;

   localparam int QDEPTH = 2;

   cmd_ctrl_type                ctrl_q_ff   [QDEPTH];
   logic [VALUE_BITS-1:0]       value_q_ff  [QDEPTH];
   logic [SLOT_BITS-1:0]        slot_q_ff   [QDEPTH];
   logic [VALUE_BITS-1:0]       dest_q_ff   [QDEPTH];
   logic [VALUE_BITS-1:0]       source_q_ff [QDEPTH];
   logic [VALUE_BITS-1:0]       length_q_ff [QDEPTH];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;
   logic                        push;
   logic                        pop;
   cmd_ctrl_type                push_ctrl;

   assign req_ready = (count_ff != 2'(QDEPTH));
   assign push      = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign pop       = head_pop && head_valid;

   always_comb begin
      push_ctrl.is_write = (req_kind == KIND_WRITE);
      push_ctrl.slot_ok  = (32'(req_slot) < TABLE_ENTRIES);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ctrl_q_ff[wr_ptr_ff]   <= push_ctrl;
         value_q_ff[wr_ptr_ff]  <= req_lookup_value;
         slot_q_ff[wr_ptr_ff]   <= req_slot;
         dest_q_ff[wr_ptr_ff]   <= req_dest_base;
         source_q_ff[wr_ptr_ff] <= req_source_base;
         length_q_ff[wr_ptr_ff] <= req_window_length;
      end
   end

   assign head_ctrl   = ctrl_q_ff[rd_ptr_ff];
   assign head_value  = value_q_ff[rd_ptr_ff];
   assign head_slot   = slot_q_ff[rd_ptr_ff];
   assign head_dest   = dest_q_ff[rd_ptr_ff];
   assign head_source = source_q_ff[rd_ptr_ff];
   assign head_length = length_q_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= 2'(QDEPTH)))
      else $error("queue fill count exceeds its depth");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not follow a lone push");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

### src/rrl_back.sv
module rrl_back #(
   parameter int TABLE_ENTRIES = 64,
   parameter int VALUE_BITS    = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rrl_pkg::COUNT_BITS-1:0] entry_count,
   input  logic                           head_valid,
   input  rrl_pkg::cmd_ctrl_type          head_ctrl,
   input  logic [VALUE_BITS-1:0]          head_value,
   input  logic [rrl_pkg::SLOT_BITS-1:0]  head_slot,
   input  logic [VALUE_BITS-1:0]          head_dest,
   input  logic [VALUE_BITS-1:0]          head_source,
   input  logic [VALUE_BITS-1:0]          head_length,
   output logic                           head_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [VALUE_BITS-1:0]          rsp_mapped_value,
   output logic                           rsp_hit,
   output logic [rrl_pkg::SLOT_BITS-1:0]  rsp_hit_slot
);
   import rrl_pkg::*;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = 3 * VALUE_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type             state_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CNT_W-1:0]      limit_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic                  found_hit_ff;
   logic [VALUE_BITS-1:0] base_ff;
   logic [VALUE_BITS-1:0] offset_ff;
   logic [IDX_W-1:0]      found_slot_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_mapped_ff;
   logic                  rsp_hit_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [VALUE_BITS-1:0] rd_dest, rd_source, rd_length;
   logic [VALUE_BITS-1:0] diff;
   logic                  match;
   logic                  last;
   logic [CNT_W-1:0]      limit_in;
   logic                  out_free;

   rrl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (IDX_W'(head_slot)),
      .wr_data ({head_dest, head_source, head_length}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign {rd_dest, rd_source, rd_length} = ram_rd_data;

   always_comb begin
      head_pop    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            head_pop  = head_valid;
            ram_wr_en = head_valid && head_ctrl.is_write && head_ctrl.slot_ok;
         end
         ST_SCAN: begin
            ram_rd_addr = cmp_idx_ff + IDX_W'(1);
         end
         default: begin
            ram_rd_addr = '0;
         end
      endcase
      diff     = value_ff - rd_source;
      match    = (value_ff >= rd_source) && (diff < rd_length);
      last     = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == limit_ff);
      limit_in = (32'(entry_count) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                    : CNT_W'(entry_count);
      out_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = ((state_ff == ST_FINISH) && out_free) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (head_valid && !head_ctrl.is_write) begin
                  value_ff   <= head_value;
                  limit_ff   <= limit_in;
                  cmp_idx_ff <= '0;
                  if (limit_in == '0) begin
                     found_hit_ff  <= 1'b0;
                     base_ff       <= head_value;
                     offset_ff     <= '0;
                     found_slot_ff <= '0;
                     state_ff      <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (match) begin
                  found_hit_ff  <= 1'b1;
                  base_ff       <= rd_dest;
                  offset_ff     <= diff;
                  found_slot_ff <= cmp_idx_ff;
                  state_ff      <= ST_FINISH;
               end else if (last) begin
                  found_hit_ff  <= 1'b0;
                  base_ff       <= value_ff;
                  offset_ff     <= '0;
                  found_slot_ff <= '0;
                  state_ff      <= ST_FINISH;
               end else begin
                  cmp_idx_ff <= cmp_idx_ff + IDX_W'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_mapped_ff <= base_ff + offset_ff;
                  rsp_hit_ff    <= found_hit_ff;
                  rsp_slot_ff   <= SLOT_BITS'(found_slot_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_value = rsp_mapped_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_slot     = rsp_slot_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(cmp_idx_ff) < limit_ff))
      else $error("scan index ran past the entry limit");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && found_hit_ff) |-> (CNT_W'(found_slot_ff) < limit_ff))
      else $error("hit recorded for a slot outside the searched range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_wr_en)
      else $error("table written during a scan");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !out_free) |=> (state_ff == ST_FINISH))
      else $error("result dropped while the output register was full");

endmodule
